// ----- sv/virtual_timer_multiplexer_assert.svh -----
// Assertion macros for the virtual timer multiplexer
`ifndef VIRTUAL_TIMER_MULTIPLEXER_ASSERT_SVH
`define VIRTUAL_TIMER_MULTIPLEXER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, quiet while reset is held
`define VTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define VTM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VTM_ASSERT(lbl, prop, msg)
`define VTM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/vtm_pkg.sv -----
// Types and constants shared by the virtual timer multiplexer
`default_nettype none

package vtm_pkg;

    localparam int KIND_W = 2;
    localparam int ID_W   = 3;
    localparam int DUR_W  = 32;

    localparam logic [KIND_W-1:0] KIND_STARTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DUE,
        ST_SEL,
        ST_EMIT
    } vtm_state_t;

endpackage

`default_nettype wire

// ----- sv/vtm_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module vtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/virtual_timer_multiplexer.sv -----
// Virtual timer multiplexer: timer slot table on one free-running time counter
//
// Command port: a beat is taken when start is high and busy is low.
//   mode = start timer: the lowest free slot is armed with deadline
//     now + duration (repeat_req marks it periodic). One result: kind
//     started with the slot as slot_id, or kind full when no slot is free.
//   mode = tick: now advances by one, then every due slot is reported as
//     kind expired, earliest deadline first (wrap-aware), ties by slot.
//     Periodic slots re-arm at now + period (period 0 counts as 1),
//     one-shot slots are freed. A tick with nothing due gives no result.
// Results appear for one cycle under result_strobe; last marks the final
// result of a command. The receiver cannot stall the block.
// Busy time: a start command stays busy while it scans the slots from the
// lowest up, and its result shows in the next cycle.
// A tick stays busy through the due scan and one selection scan per
// expiry (one when nothing is due); the slot scan over one RAM read port
// and one shared adder/subtractor sets it. The next command may be taken
// in the cycle that shows the final result.
// Reset clears the time counter and frees every slot; no RAM clearing pass.
`default_nettype none

`include "virtual_timer_multiplexer_assert.svh"

module virtual_timer_multiplexer #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       mode,
    input  wire logic [vtm_pkg::DUR_W-1:0]  duration,
    input  wire logic                       repeat_req,
    output logic                            result_strobe,
    output logic      [vtm_pkg::KIND_W-1:0] kind,
    output logic      [vtm_pkg::ID_W-1:0]   slot_id,
    output logic                            last
);

    import vtm_pkg::*;

    localparam int IW     = $clog2(NUM_TIMERS);
    localparam int TW     = TIME_WIDTH;
    localparam int WORD_W = 2 * TW + 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_TIMERS - 1);
    localparam logic [TW-1:0] T_ONE     = TW'(1);
    localparam logic [TW-1:0] T_SIGN    = TW'(1) << (TW - 1);

    // slot number to result id, masked to the id width
    function automatic logic [ID_W-1:0] to_id(input logic [IW-1:0] s);
        logic [IW+ID_W-1:0] w;
        w = (IW + ID_W)'(s);
        return w[ID_W-1:0];
    endfunction

    // control state
    vtm_state_t            state_reg, state_next;
    logic [TW-1:0]         now_reg, now_next;
    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    logic [NUM_TIMERS-1:0] due_reg, due_next;
    logic [IW-1:0]         cnt_reg, cnt_next;
    logic                  iss_reg, iss_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  found_reg, found_next;
    logic                  stb_reg, stb_next;

    // payload
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic [IW-1:0]         best_reg, best_next;
    logic [TW-1:0]         best_key_reg, best_key_next;
    logic [TW-1:0]         best_per_reg, best_per_next;
    logic                  best_rep_reg, best_rep_next;
    logic [TW-1:0]         dur_reg, dur_next;
    logic                  rep_reg, rep_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic                  last_reg, last_next;

    // slot RAM: {repeat, period, deadline}
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;
    logic [TW-1:0]         rd_deadline;
    logic [TW-1:0]         rd_period;
    logic                  rd_repeat;

    // shared adder and subtractor
    logic [TW-1:0]         add_b;
    logic [TW-1:0]         add_sum;
    logic [TW-1:0]         diff;
    logic [TW-1:0]         key;
    logic                  accept;
    logic [NUM_TIMERS-1:0] due_left;

    vtm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_deadline = ram_rdata[TW-1:0];
    assign rd_period   = ram_rdata[2*TW-1:TW];
    assign rd_repeat   = ram_rdata[2*TW];

    assign add_sum = now_reg + add_b;
    assign diff    = rd_deadline - now_reg;
    assign key     = diff ^ T_SIGN;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign due_left = due_reg & ~(NUM_TIMERS'(1) << best_reg);

    assign result_strobe = stb_reg;
    assign kind          = kind_reg;
    assign slot_id       = id_reg;
    assign last          = last_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            valid_reg   <= '0;
            due_reg     <= '0;
            cnt_reg     <= '0;
            iss_reg     <= 1'b0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            stb_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            valid_reg   <= valid_next;
            due_reg     <= due_next;
            cnt_reg     <= cnt_next;
            iss_reg     <= iss_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            stb_reg     <= stb_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        best_per_reg <= best_per_next;
        best_rep_reg <= best_rep_next;
        dur_reg      <= dur_next;
        rep_reg      <= rep_next;
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        last_reg     <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        valid_next    = valid_reg;
        due_next      = due_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        chk_vld_next  = iss_reg;
        chk_idx_next  = cnt_reg;
        found_next    = found_reg;
        stb_next      = 1'b0;
        best_next     = best_reg;
        best_key_next = best_key_reg;
        best_per_next = best_per_reg;
        best_rep_next = best_rep_reg;
        dur_next      = dur_reg;
        rep_next      = rep_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = {rep_reg, dur_reg, add_sum};
        add_b         = T_ONE;

        // issue counter walks the RAM one slot a cycle
        if (iss_reg)
        begin
            if (cnt_reg == LAST_SLOT)
            begin
                iss_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + IW'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                add_b = T_ONE;
                if (accept)
                begin
                    cnt_next     = '0;
                    chk_vld_next = 1'b0;
                    if (mode == MODE_START)
                    begin
                        dur_next   = TW'(duration);
                        rep_next   = repeat_req;
                        iss_next   = 1'b0;
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        now_next   = add_sum;
                        due_next   = '0;
                        iss_next   = 1'b1;
                        state_next = ST_DUE;
                    end
                end
            end

            // lowest free slot, one valid bit a cycle
            ST_FIND:
            begin
                add_b = dur_reg;
                if (!valid_reg[cnt_reg])
                begin
                    ram_we              = 1'b1;
                    valid_next[cnt_reg] = 1'b1;
                    stb_next            = 1'b1;
                    kind_next           = KIND_STARTED;
                    id_next             = to_id(cnt_reg);
                    last_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    stb_next   = 1'b1;
                    kind_next  = KIND_FULL;
                    id_next    = '0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end

            // mark due slots: deadline - now zero or negative
            ST_DUE:
            begin
                if (chk_vld_reg)
                begin
                    due_next[chk_idx_reg] = valid_reg[chk_idx_reg]
                                          && (diff == '0 || diff[TW-1]);
                    if (chk_idx_reg == LAST_SLOT)
                    begin
                        cnt_next     = '0;
                        iss_next     = 1'b1;
                        chk_vld_next = 1'b0;
                        found_next   = 1'b0;
                        state_next   = ST_SEL;
                    end
                end
            end

            // earliest remaining due slot, ties kept by lower slot
            ST_SEL:
            begin
                if (chk_vld_reg)
                begin
                    if (due_reg[chk_idx_reg] && (!found_reg || key < best_key_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = chk_idx_reg;
                        best_key_next = key;
                        best_per_next = rd_period;
                        best_rep_next = rd_repeat;
                    end
                    if (chk_idx_reg == LAST_SLOT)
                    begin
                        state_next = found_next ? ST_EMIT : ST_IDLE;
                    end
                end
            end

            // report the chosen slot and re-arm or free it
            ST_EMIT:
            begin
                add_b     = (best_per_reg == '0) ? T_ONE : best_per_reg;
                ram_waddr = best_reg;
                ram_wdata = {best_rep_reg, best_per_reg, add_sum};
                if (best_rep_reg)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    valid_next[best_reg] = 1'b0;
                end
                due_next  = due_left;
                stb_next  = 1'b1;
                kind_next = KIND_EXPIRED;
                id_next   = to_id(best_reg);
                last_next = (due_left == '0);
                if (due_left == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next     = '0;
                    iss_next     = 1'b1;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    state_next   = ST_SEL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `VTM_ASSERT(a_accept_busy, accept |=> busy, "accepted command did not raise busy")
    `VTM_ASSERT(a_last_idle, stb_reg && last_reg |-> !busy, "final beat while still busy")
    `VTM_ASSERT(a_more_busy, stb_reg && !last_reg |-> busy, "non-final beat with sequencer idle")
    `VTM_ASSERT(a_due_valid, (due_reg & ~valid_reg) == '0, "due mark on a free slot")
    `VTM_ASSERT(a_emit_due, state_reg == ST_EMIT |-> due_reg[best_reg], "reporting a slot not due")

endmodule

`default_nettype wire
